### rtl/alu64_pkg.sv
// Package for the 64-bit integer ALU: operation codes, item structs and the
// control word that travels with each item down the divider chain.
// Depends on nothing.
`default_nettype none
package alu64_pkg;

    typedef enum logic [3:0] {
        K_NOT = 4'd0,  K_AND = 4'd1,  K_OR  = 4'd2,  K_XOR = 4'd3,
        K_SHL = 4'd4,  K_SAR = 4'd5,  K_SHR = 4'd6,  K_ROR = 4'd7,
        K_ROL = 4'd8,  K_INC = 4'd9,  K_DEC = 4'd10, K_ADD = 4'd11,
        K_SUB = 4'd12, K_MUL = 4'd13, K_DIV = 4'd14, K_MOD = 4'd15
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] result;
        logic               divide_by_zero;
    } t_out_item;

    // Control word of one item in flight.
    typedef struct packed {
        logic valid;
        logic is_div;
        logic is_mod;
        logic q_neg;
        logic r_neg;
        logic dz;
    } t_ctl;

endpackage
`default_nettype wire

### rtl/alu_64bit_integer_core.sv
// Integer ALU, DATA_WIDTH bits wide. An item passes through two front stages,
// one divider cell per quotient bit, then the output register.
// Throughput is one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall at the output holds it.
// Reset (synchronous, active low) clears every valid flag in the pipeline.
`default_nettype none
module alu_64bit_integer_core
    import alu64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);
    localparam int W = DATA_WIDTH;

    // One global advance signal: the chain moves as a whole.
    logic en;

    t_ctl         ctl  [0:W];
    logic [W-1:0] side [0:W];
    logic [W-1:0] dsr  [0:W];
    logic [W-1:0] rem  [0:W];
    logic [W-1:0] quo  [0:W];

    logic         r_out_valid;
    t_out_item    r_out_item;
    logic [W-1:0] n_res;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    alu64_front #(.W(W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_item     (i_in_item),
        .o_ctl      (ctl[0]),
        .o_side     (side[0]),
        .o_divisor  (dsr[0]),
        .o_dividend (quo[0])
    );
    assign rem[0] = '0;

    // The chain of division cells: each retires one quotient bit, MSB first.
    for (genvar g = 0; g < W; g++) begin : g_cell
        alu64_div_cell #(.W(W)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_ctl     (ctl[g]),
            .i_side    (side[g]),
            .i_divisor (dsr[g]),
            .i_rem     (rem[g]),
            .i_quo     (quo[g]),
            .o_ctl     (ctl[g+1]),
            .o_side    (side[g+1]),
            .o_divisor (dsr[g+1]),
            .o_rem     (rem[g+1]),
            .o_quo     (quo[g+1])
        );
    end

    // Final select. A zero divisor already left its answer in the side word.
    always_comb begin
        if (ctl[W].dz) begin
            n_res = side[W];
        end else if (ctl[W].is_div) begin
            n_res = ctl[W].q_neg ? (W'(0) - quo[W]) : quo[W];
        end else if (ctl[W].is_mod) begin
            n_res = ctl[W].r_neg ? (W'(0) - rem[W]) : rem[W];
        end else begin
            n_res = side[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.result         <= 64'($signed(n_res));
            r_out_item.divide_by_zero <= ctl[W].dz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule
`default_nettype wire

### rtl/alu64_front.sv
// Front end of the ALU: two register stages that decode the item, run the
// logic, shift and add operations, build the product and prepare division.
// Depends on alu64_pkg.
`default_nettype none
module alu64_front
    import alu64_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire t_in_item     i_item,
    output t_ctl              o_ctl,
    output logic [W-1:0]      o_side,
    output logic [W-1:0]      o_divisor,
    output logic [W-1:0]      o_dividend
);
    localparam int LO = W / 2;

    logic [W-1:0]    a, b, ma, mb, simple;
    logic [5:0]      cnt;
    logic [6:0]      rc;
    logic [2*LO-1:0] pll;
    logic [W-1:0]    p1, p2;
    t_ctl            ctl;

    t_ctl         r_ctl1, r_ctl2;
    logic         r_mul1;
    logic [W-1:0] r_ll, r_cross, r_simple, r_ma, r_mb;
    logic [W-1:0] r_side, r_divisor, r_dividend;

    always_comb begin
        a   = i_item.operand_a[W-1:0];
        b   = i_item.operand_b[W-1:0];
        cnt = a[5:0];
        rc  = {1'b0, cnt};
        for (int i = 0; i < 8; i++) begin
            if (rc >= 7'(W)) begin
                rc = rc - 7'(W);
            end
        end
        ma  = a[W-1] ? (W'(0) - a) : a;
        mb  = b[W-1] ? (W'(0) - b) : b;
        pll = a[LO-1:0] * b[LO-1:0];
        p1  = a[LO-1:0] * b[W-1:LO];
        p2  = a[W-1:LO] * b[LO-1:0];
        case (i_item.kind)
            K_NOT:   simple = ~a;
            K_AND:   simple = b & a;
            K_OR:    simple = b | a;
            K_XOR:   simple = b ^ a;
            K_SHL:   simple = b << cnt;
            K_SAR:   simple = $unsigned($signed(b) >>> cnt);
            K_SHR:   simple = b >> cnt;
            K_ROR:   simple = (b >> rc) | (b << (7'(W) - rc));
            K_ROL:   simple = (b << rc) | (b >> (7'(W) - rc));
            K_INC:   simple = a + W'(1);
            K_DEC:   simple = a - W'(1);
            K_ADD:   simple = b + a;
            K_SUB:   simple = b - a;
            K_DIV:   simple = '1;
            K_MOD:   simple = b;
            default: simple = '0;
        endcase
        ctl.valid  = i_valid;
        ctl.is_div = (i_item.kind == K_DIV);
        ctl.is_mod = (i_item.kind == K_MOD);
        ctl.q_neg  = a[W-1] ^ b[W-1];
        ctl.r_neg  = b[W-1];
        ctl.dz     = (ctl.is_div || ctl.is_mod) && (a == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mul1     <= (i_item.kind == K_MUL);
            r_ll       <= W'(pll);
            r_cross    <= p1 + p2;
            r_simple   <= simple;
            r_ma       <= ma;
            r_mb       <= mb;
            r_side     <= r_mul1 ? (r_ll + (r_cross << LO)) : r_simple;
            r_divisor  <= r_ma;
            r_dividend <= r_mb;
        end
    end

    assign o_ctl      = r_ctl2;
    assign o_side     = r_side;
    assign o_divisor  = r_divisor;
    assign o_dividend = r_dividend;
endmodule
`default_nettype wire

### rtl/alu64_div_cell.sv
// One cell of the divider chain: a single restoring division step that
// yields one quotient bit and hands everything on to the next cell.
// Depends on alu64_pkg.
`default_nettype none
module alu64_div_cell
    import alu64_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_ctl         i_ctl,
    input  wire logic [W-1:0] i_side,
    input  wire logic [W-1:0] i_divisor,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_quo,
    output t_ctl              o_ctl,
    output logic [W-1:0]      o_side,
    output logic [W-1:0]      o_divisor,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_quo
);
    logic [W:0]   trial, diff;
    logic         qbit;
    t_ctl         r_ctl;
    logic [W-1:0] r_side, r_divisor, r_rem, r_quo;

    always_comb begin
        trial = {i_rem, i_quo[W-1]};
        diff  = trial - {1'b0, i_divisor};
        qbit  = !diff[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side    <= i_side;
            r_divisor <= i_divisor;
            r_rem     <= qbit ? diff[W-1:0] : trial[W-1:0];
            r_quo     <= {i_quo[W-2:0], qbit};
        end
    end

    assign o_ctl     = r_ctl;
    assign o_side    = r_side;
    assign o_divisor = r_divisor;
    assign o_rem     = r_rem;
    assign o_quo     = r_quo;
endmodule
`default_nettype wire
